// File: src/ec2d_pkg.sv
package ec2d_pkg;

	typedef struct packed {
		logic [5:0] second;
		logic [5:0] minute;
		logic [4:0] hour;
	} hms_t;

	typedef struct packed {
		hms_t        hms;
		logic [14:0] days;
		logic [6:0]  year_ofs;
	} days_t;

	typedef struct packed {
		hms_t       hms;
		logic [7:0] year;
		logic [8:0] yday;
		logic       leap;
	} yday_t;

	typedef struct packed {
		hms_t       hms;
		logic [4:0] month_day;
		logic [3:0] month;
		logic [7:0] year;
		logic [2:0] week_day;
		logic [8:0] year_day;
	} date_t;

endpackage

// File: src/ec2d_split.sv
module ec2d_split (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	input  logic [30:0]          secs,
	output logic                 out_vld,
	output ec2d_pkg::days_t      out
);
	import ec2d_pkg::*;

	localparam logic [31:0] RCP_60A = 32'(((64'd1 << 37) + 64'd59) / 64'd60);
	localparam logic [26:0] RCP_60B = 27'(((64'd1 << 32) + 64'd59) / 64'd60);
	localparam logic [20:0] RCP_24  = 21'(((64'd1 << 25) + 64'd23) / 64'd24);
	localparam logic [15:0] RCP_365 = 16'(((64'd1 << 24) + 64'd364) / 64'd365);

	logic [62:0] prod1;
	logic [52:0] prod2;
	logic [40:0] prod3;
	logic [30:0] prod4;

	logic        vld_s1, vld_s2, vld_s3, vld_s4;
	logic [30:0] t_s1;
	logic [25:0] q1_s1, q1_s2;
	logic [5:0]  sec_s2, sec_s3, sec_s4;
	logic [19:0] q2_s2, q2_s3;
	logic [5:0]  min_s3, min_s4;
	logic [14:0] q3_s3, days_s4;
	logic [4:0]  hr_s4;
	logic [6:0]  yq_s4;

	assign prod1 = 63'(secs) * 63'(RCP_60A);
	assign prod2 = 53'(q1_s1) * 53'(RCP_60B);
	assign prod3 = 41'(q2_s2) * 41'(RCP_24);
	assign prod4 = 31'(q3_s3) * 31'(RCP_365);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		t_s1    <= secs;
		q1_s1   <= 26'(prod1 >> 37);
		sec_s2  <= t_s1[5:0] - 6'(q1_s1[5:0] * 6'd60);
		q1_s2   <= q1_s1;
		q2_s2   <= 20'(prod2 >> 32);
		sec_s3  <= sec_s2;
		min_s3  <= q1_s2[5:0] - 6'(q2_s2[5:0] * 6'd60);
		q2_s3   <= q2_s2;
		q3_s3   <= 15'(prod3 >> 25);
		sec_s4  <= sec_s3;
		min_s4  <= min_s3;
		hr_s4   <= q2_s3[4:0] - 5'(q3_s3[4:0] * 5'd24);
		days_s4 <= q3_s3;
		yq_s4   <= 7'(prod4 >> 24);
	end

	assign out_vld         = vld_s4;
	assign out.hms.second  = sec_s4;
	assign out.hms.minute  = min_s4;
	assign out.hms.hour    = hr_s4;
	assign out.days        = days_s4;
	assign out.year_ofs    = yq_s4;

endmodule

// File: src/ec2d_year.sv
module ec2d_year (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  ec2d_pkg::days_t in,
	output logic            out_vld,
	output ec2d_pkg::yday_t out
);
	import ec2d_pkg::*;

	localparam logic [7:0] EPOCH_YEAR = 8'd70;
	localparam logic [9:0] DAYS_YEAR  = 10'd365;

	function automatic logic is_leap(input logic [7:0] ys);
		return (ys[1:0] == 2'd0) && (ys != 8'd0) && (ys != 8'd200);
	endfunction

	logic [8:0] rem_d;
	logic [4:0] ld_d;
	logic [9:0] diff;
	logic       neg;
	logic [7:0] ysm;
	logic [9:0] fix;

	logic       vld_s5, vld_s6;
	hms_t       hms_s5;
	logic [8:0] rem_s5;
	logic [4:0] ld_s5;
	logic [7:0] ys_s5;
	yday_t      res_s6;

	always_comb begin
		rem_d = 9'(in.days - 15'(in.year_ofs) * 15'd365);
		ld_d  = 5'((8'(in.year_ofs) + 8'd1) >> 2)
			- 5'((8'(in.year_ofs) + 8'd69) >= 8'd100)
			+ 5'((10'(in.year_ofs) + 10'd369) >= 10'd400);
		diff  = 10'(rem_s5) - 10'(ld_s5);
		neg   = diff[9];
		ysm   = ys_s5 - 8'd1;
		fix   = diff + DAYS_YEAR + 10'(is_leap(ysm));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s5 <= in_vld;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		hms_s5      <= in.hms;
		rem_s5      <= rem_d;
		ld_s5       <= ld_d;
		ys_s5       <= EPOCH_YEAR + 8'(in.year_ofs);
		res_s6.hms  <= hms_s5;
		res_s6.year <= neg ? ysm : ys_s5;
		res_s6.yday <= neg ? fix[8:0] : diff[8:0];
		res_s6.leap <= neg ? is_leap(ysm) : is_leap(ys_s5);
	end

	assign out_vld = vld_s6;
	assign out     = res_s6;

endmodule

// File: src/ec2d_cal.sv
module ec2d_cal (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  ec2d_pkg::yday_t in,
	output logic            out_vld,
	output ec2d_pkg::date_t out
);
	import ec2d_pkg::*;

	localparam logic [13:0] RCP_489 = 14'(((64'd1 << 22) + 64'd488) / 64'd489);
	localparam logic [8:0]  RCP_7   = 9'(((64'd1 << 11) + 64'd6) / 64'd7);

	function automatic logic [8:0] mday_base(input logic [3:0] m);
		logic [12:0] p;
		p = 13'(m) * 13'd489;
		return p[12:4];
	endfunction

	function automatic logic [2:0] wday_ofs(input logic [3:0] mon);
		logic [2:0] r;
		case (mon)
			4'd0:    r = 3'd0;
			4'd1:    r = 3'd3;
			4'd2:    r = 3'd2;
			4'd3:    r = 3'd5;
			4'd4:    r = 3'd0;
			4'd5:    r = 3'd3;
			4'd6:    r = 3'd5;
			4'd7:    r = 3'd1;
			4'd8:    r = 3'd4;
			4'd9:    r = 3'd6;
			4'd10:   r = 3'd2;
			4'd11:   r = 3'd4;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	logic [8:0]  yd_d;
	logic [1:0]  adj;
	logic [8:0]  a_d;
	logic [22:0] prod_mon;
	logic [3:0]  monq;
	logic [3:0]  mon_d;
	logic [3:0]  m;
	logic [9:0]  mday_w;
	logic [7:0]  w_d;
	logic [7:0]  sum_d;
	logic [16:0] prod_wk;

	logic        vld_s7, vld_s8, vld_s9, vld_s10, vld_s11, vld_s12;
	yday_t       p_s7, p_s8, p_s9, p_s10, p_s11;
	logic [8:0]  yd_s7, yd_s8;
	logic [8:0]  a_s7;
	logic [3:0]  mon_s8, mon_s9, mon_s10, mon_s11;
	logic [4:0]  mday_s9, mday_s10, mday_s11;
	logic [7:0]  w_s9;
	logic [7:0]  x_s10, x_s11;
	logic [5:0]  q_s11;
	date_t       res_s12;

	always_comb begin
		yd_d     = in.yday + 9'd1;
		adj      = in.leap ? 2'd1 : 2'd2;
		a_d      = yd_d + 9'd30
			+ (((10'(yd_d) + 10'(in.leap)) >= 10'd60) ? 9'(adj) : 9'd0);
		prod_mon = 23'(a_s7) * 23'(RCP_489);
		monq     = 4'(prod_mon >> 18);
		if (monq == 4'd0)
			mon_d = 4'd0;
		else if (monq > 4'd12)
			mon_d = 4'd11;
		else
			mon_d = monq - 4'd1;
		m        = mon_s8 + 4'd1;
		mday_w   = 10'(yd_s8) + 10'd30 - 10'(mday_base(m))
			+ ((m >= 4'd3) ? (p_s8.leap ? 10'd1 : 10'd2) : 10'd0);
		w_d      = p_s8.year - ((m < 4'd3) ? 8'd1 : 8'd0);
		sum_d    = 8'd1 + w_s9 + (w_s9 >> 2) + 8'(wday_ofs(mon_s9)) + 8'(mday_s9);
		prod_wk  = 17'(x_s10) * 17'(RCP_7);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
		end else begin
			vld_s7  <= in_vld;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
		end
	end

	always_ff @(posedge clk) begin
		p_s7     <= in;
		yd_s7    <= yd_d;
		a_s7     <= a_d;
		p_s8     <= p_s7;
		yd_s8    <= yd_s7;
		mon_s8   <= mon_d;
		p_s9     <= p_s8;
		mon_s9   <= mon_s8;
		mday_s9  <= mday_w[4:0];
		w_s9     <= w_d;
		p_s10    <= p_s9;
		mon_s10  <= mon_s9;
		mday_s10 <= mday_s9;
		x_s10    <= sum_d;
		p_s11    <= p_s10;
		mon_s11  <= mon_s10;
		mday_s11 <= mday_s10;
		x_s11    <= x_s10;
		q_s11    <= 6'(prod_wk >> 11);
		res_s12.hms       <= p_s11.hms;
		res_s12.month_day <= mday_s11;
		res_s12.month     <= mon_s11;
		res_s12.year      <= p_s11.year;
		res_s12.week_day  <= x_s11[2:0] - 3'(q_s11[2:0] * 3'd7);
		res_s12.year_day  <= p_s11.yday;
	end

	assign out_vld = vld_s12;
	assign out     = res_s12;

endmodule

// File: src/epoch_seconds_to_civil_date_core.sv
// Converts a 31-bit count of seconds since 1970-01-01 00:00:00 UTC into UTC
// calendar date and time of day. busy stays low: a request is taken on every
// cycle that start is high, and its result appears on the output ports with
// done high for one cycle, in request order, through a twelve-stage
// pipeline: four reciprocal-multiply stages split seconds, minutes, hours,
// days and the year estimate, two stages resolve the year and day of year,
// six stages derive month, day of month and day of week. The receiver cannot
// stall, so results must be captured on the cycle done is high.
module epoch_seconds_to_civil_date_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [30:0] epoch_seconds,
	output logic        done,
	output logic [5:0]  second,
	output logic [5:0]  minute,
	output logic [4:0]  hour,
	output logic [4:0]  month_day,
	output logic [3:0]  month,
	output logic [7:0]  year_since_1900,
	output logic [2:0]  week_day,
	output logic [8:0]  year_day
);
	import ec2d_pkg::*;

	logic  in_vld;
	logic  days_vld;
	days_t days;
	logic  yday_vld;
	yday_t yday;
	date_t date;

	assign busy   = 1'b0;
	assign in_vld = start & ~busy;

	ec2d_split u_split (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (in_vld),
		.secs    (epoch_seconds),
		.out_vld (days_vld),
		.out     (days)
	);

	ec2d_year u_year (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (days_vld),
		.in      (days),
		.out_vld (yday_vld),
		.out     (yday)
	);

	ec2d_cal u_cal (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (yday_vld),
		.in      (yday),
		.out_vld (done),
		.out     (date)
	);

	assign second          = date.hms.second;
	assign minute          = date.hms.minute;
	assign hour            = date.hms.hour;
	assign month_day       = date.month_day;
	assign month           = date.month;
	assign year_since_1900 = date.year;
	assign week_day        = date.week_day;
	assign year_day        = date.year_day;

endmodule

// File: bench/civil_date_checker.sv
module civil_date_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [30:0] epoch_seconds,
	input  logic        done,
	input  logic [5:0]  second,
	input  logic [5:0]  minute,
	input  logic [4:0]  hour,
	input  logic [4:0]  month_day,
	input  logic [3:0]  month,
	input  logic [7:0]  year_since_1900,
	input  logic [2:0]  week_day,
	input  logic [8:0]  year_day,
	output int          mismatches,
	output int          outstanding,
	output int          results_seen,
	output int          year_fixups
);
	timeunit 1ns;
	timeprecision 1ps;

	import ec2d_pkg::*;

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [30:0] secs;
		date_t       civil;
	} dated_request_t;

	int month_shift [12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};

	dated_request_t pending_dates [$];

	function automatic int leap_flag(input int y);
		return ((y % 4 == 0) ? 1 : 0) - ((y % 100 == 0) ? 1 : 0) + ((y % 400 == 0) ? 1 : 0);
	endfunction

	function automatic int leaps_before(input int y);
		int p;
		p = y - 1;
		return (p - 1968) / 4 - (p - 1900) / 100 + (p - 1600) / 400;
	endfunction

	function automatic date_t civil_from_epoch(input logic [30:0] secs, output bit stepped);
		int unsigned rest;
		int unsigned days;
		int yr, yd, lp, mo, mn, md, d1, wy, wd;
		date_t r;
		rest = 32'(secs);
		r.hms.second = 6'(rest % 60);
		rest = rest / 60;
		r.hms.minute = 6'(rest % 60);
		rest = rest / 60;
		r.hms.hour = 5'(rest % 24);
		days = rest / 24;
		yr = 1970 + int'(days / 365);
		yd = int'(days % 365) - leaps_before(yr);
		stepped = (yd < 0);
		// pull the year back when the leap-day correction overshoots
		if (yd < 0) begin
			yr = yr - 1;
			yd = yd + ((leap_flag(yr) != 0) ? 366 : 365);
		end
		lp = leap_flag(yr);
		d1 = yd + 1;
		mo = (d1 + 30 + (d1 + lp + 400) / 460 * (2 - lp)) * 16 / 489 - 1;
		if (mo < 0)
			mo = 0;
		if (mo > 11)
			mo = 11;
		mn = mo + 1;
		md = d1 + 30 - 489 * mn / 16 + (7 + mn) / 10 * (2 - lp);
		wy = yr - ((mn < 3) ? 1 : 0);
		wd = (wy + wy / 4 - wy / 100 + wy / 400 + month_shift[mn - 1] + md) % 7;
		r.month_day = 5'(md);
		r.month = 4'(mo);
		r.year = 8'(yr - 1900);
		r.week_day = 3'(wd);
		r.year_day = 9'(yd);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		dated_request_t want;
		date_t got;
		date_t civil;
		bit stepped;
		if (!arst_n) begin
			pending_dates.delete();
			mismatches = 0;
			outstanding = 0;
			results_seen = 0;
			year_fixups = 0;
		end else begin
			if (done) begin
				got.hms.second = second;
				got.hms.minute = minute;
				got.hms.hour = hour;
				got.month_day = month_day;
				got.month = month;
				got.year = year_since_1900;
				got.week_day = week_day;
				got.year_day = year_day;
				results_seen++;
				if (pending_dates.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: unexpected result %0d:%0d:%0d day %0d month %0d year %0d",
							$realtime, hour, minute, second, month_day, month,
							year_since_1900);
				end else begin
					want = pending_dates.pop_front();
					if (got !== want.civil) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT) begin
							$display("%0t: mismatch for %0d s", $realtime, want.secs);
							$display("  expected %0d:%0d:%0d mday %0d mon %0d year %0d wday %0d yday %0d",
								want.civil.hms.hour, want.civil.hms.minute,
								want.civil.hms.second, want.civil.month_day,
								want.civil.month, want.civil.year,
								want.civil.week_day, want.civil.year_day);
							$display("  actual   %0d:%0d:%0d mday %0d mon %0d year %0d wday %0d yday %0d",
								hour, minute, second, month_day, month,
								year_since_1900, week_day, year_day);
						end
					end
				end
			end
			if (start && !busy) begin
				civil = civil_from_epoch(epoch_seconds, stepped);
				pending_dates.push_back({epoch_seconds, civil});
				if (stepped)
					year_fixups++;
			end
			outstanding = pending_dates.size();
		end
	end

endmodule

// File: bench/epoch_seconds_to_civil_date_core_test.sv
module epoch_seconds_to_civil_date_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     RANDOM_REQUESTS = 650;
	localparam int     QUIET_LIMIT = 2000;
	localparam int     LANDMARK_COUNT = 22;
	localparam longint LAST_SECOND = 64'd2147483647;
	localparam longint LAST_DAY = 24855;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [30:0] epoch_seconds;
	logic        done;
	logic [5:0]  second;
	logic [5:0]  minute;
	logic [4:0]  hour;
	logic [4:0]  month_day;
	logic [3:0]  month;
	logic [7:0]  year_since_1900;
	logic [2:0]  week_day;
	logic [8:0]  year_day;
	int          mismatches;
	int          outstanding;
	int          results_seen;
	int          year_fixups;
	int          quiet_cycles;

	logic [30:0] landmarks [LANDMARK_COUNT] = '{
		31'd0, 31'd1, 31'd59, 31'd60, 31'd3599, 31'd3600, 31'd86399, 31'd86400,
		31'd5097599, 31'd5097600, 31'd31535999, 31'd31536000, 31'd68169600,
		31'd94608000, 31'd94694399, 31'd94694400, 31'd951782400, 31'd978220800,
		31'd2114294400, 31'd1431655765, 31'd715827882, 31'd2147483647
	};

	epoch_seconds_to_civil_date_core uut (.*);

	civil_date_checker check (.*);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout after %0d quiet cycles", quiet_cycles);
			$display("epoch_seconds_to_civil_date_core regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_request(input logic [30:0] secs, input bit steady);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 9) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		epoch_seconds <= secs;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	initial begin
		longint t;
		int     n;
		int     y;
		int     d;
		int     k;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		epoch_seconds = '0;
		quiet_cycles = 0;
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (n = 0; n < LANDMARK_COUNT; n++)
			send_request(landmarks[n], 1'b0);

		for (n = 0; n < RANDOM_REQUESTS; n++) begin
			// drain the pipeline once mid-run
			if (n == 400) begin
				@(negedge clk);
				start <= 1'b0;
				while (outstanding != 0)
					@(negedge clk);
			end
			case ($urandom_range(0, 3))
				0, 1: t = longint'($urandom & 32'h7fff_ffff);
				2: begin
					t = longint'($urandom_range(0, LAST_DAY)) * 86400;
					t = t + ($urandom_range(0, 1) ? 86399 - $urandom_range(0, 2)
						: $urandom_range(0, 2));
				end
				default: begin
					y = $urandom_range(1970, 2038);
					d = 0;
					for (k = 1970; k < y; k++)
						d = d + (((k % 4 == 0 && k % 100 != 0) || k % 400 == 0) ? 366 : 365);
					d = d + $urandom_range(0, 2) - 1;
					t = longint'(d) * 86400 + $urandom_range(0, 86399);
				end
			endcase
			if (t < 0)
				t = $urandom_range(0, 86399);
			if (t > LAST_SECOND)
				t = LAST_SECOND - $urandom_range(0, 4000);
			send_request(t[30:0], n >= 150 && n < 350);
		end

		@(negedge clk);
		start <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (20)
			@(posedge clk);

		$display("%0d requests (%0d landmark times), %0d results checked",
			LANDMARK_COUNT + RANDOM_REQUESTS, LANDMARK_COUNT, results_seen);
		$display("%0d dates needed the year estimate pulled back, %0d mismatches",
			year_fixups, mismatches);
		if (mismatches == 0 && outstanding == 0)
			$display("epoch_seconds_to_civil_date_core regression: pass");
		else
			$display("epoch_seconds_to_civil_date_core regression: fail");
		$finish;
	end

endmodule
